// ===== rtl/segmented_sum_min_max_argreduce_macros.svh =====
// Assertion macros for the segmented reduction block.
`ifndef SEGMENTED_SUM_MIN_MAX_ARGREDUCE_MACROS_SVH
`define SEGMENTED_SUM_MIN_MAX_ARGREDUCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSMM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssmm_pkg.sv =====
// Package with the widths, mode codes, request type codes and memory entry type of the segmented reduction block.
package ssmm_pkg;

    localparam int GROUPS  = 1024;
    localparam int GROUP_W = 10;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;
    localparam int INDEX_W = 17;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic               seen;
        logic [POS_W-1:0]   index;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

// ===== rtl/segmented_sum_min_max_argreduce.sv =====
// Top level of the segmented reduction block: one accumulator per group in a single memory.
//
//  channel   direction  handshake             fields
//  request   in         start high, busy low  req_type, group_id, element_value, position_in_group
//  result    out        result_valid strobe   result_group, result_value, result_index, group_empty
//  config    in         cfg_we                cfg_data (reduce_mode)
//
// Each accepted word first reads its group's entry from the memory, then modifies it and writes
// it back; busy stays high until the write-back, so no new word is taken before it is done.
// A readout word gives its result in the cycle after the write-back; an accumulate gives none.
// After reset the block sweeps all 1024 entries empty, one per cycle, with busy held high.
// The receiver cannot stall: each result is valid for exactly one cycle.
`include "segmented_sum_min_max_argreduce_macros.svh"

module segmented_sum_min_max_argreduce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssmm_pkg::MODE_W-1:0]         cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [ssmm_pkg::GROUP_W-1:0]        group_id,
    input  logic signed [ssmm_pkg::VALUE_W-1:0] element_value,
    input  logic [ssmm_pkg::POS_W-1:0]          position_in_group,
    output logic                                result_valid,
    output logic [ssmm_pkg::GROUP_W-1:0]        result_group,
    output logic signed [ssmm_pkg::VALUE_W-1:0] result_value,
    output logic signed [ssmm_pkg::INDEX_W-1:0] result_index,
    output logic                                group_empty
);

    import ssmm_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    entry_t               mem [GROUPS];
    entry_t               rd_data_reg;

    logic [1:0]           state_reg, state_next;
    logic [GROUP_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [MODE_W-1:0]    mode_reg;

    logic                 req_reg;
    logic [GROUP_W-1:0]   grp_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [POS_W-1:0]     pos_reg;

    logic                 res_valid_reg, res_valid_next;
    logic [GROUP_W-1:0]   res_group_reg;
    logic [VALUE_W-1:0]   res_value_reg, res_value_next;
    logic [INDEX_W-1:0]   res_index_reg, res_index_next;
    logic                 res_empty_reg, res_empty_next;

    logic                 accept;
    logic                 wr_en;
    logic [GROUP_W-1:0]   wr_addr;
    entry_t               wr_data;
    logic                 is_min;
    logic                 is_max;
    logic                 better;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign is_min = (mode_reg == MODE_MIN);
    assign is_max = (mode_reg == MODE_MAX);
    assign better = is_min ? ($signed(val_reg) < $signed(rd_data_reg.value))
                           : ($signed(rd_data_reg.value) < $signed(val_reg));

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[group_id];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = grp_reg;
        wr_data        = rd_data_reg;
        res_valid_next = 1'b0;
        res_value_next = '0;
        res_index_next = '1;
        res_empty_next = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + GROUP_W'(1);
                if (clr_addr_reg == GROUP_W'(GROUPS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
                if (req_reg == REQ_ACCUM)
                begin
                    if (!rd_data_reg.seen)
                    begin
                        wr_data = '{seen: 1'b1, index: pos_reg, value: val_reg};
                    end
                    else if (!is_min && !is_max)
                    begin
                        wr_data.value = rd_data_reg.value + val_reg;
                    end
                    else if (better)
                    begin
                        wr_data = '{seen: 1'b1, index: pos_reg, value: val_reg};
                    end
                    else if ((val_reg == rd_data_reg.value) && (pos_reg > rd_data_reg.index))
                    begin
                        wr_data.index = pos_reg;
                    end
                end
                else
                begin
                    wr_data.seen   = 1'b0;
                    res_valid_next = 1'b1;
                    if (rd_data_reg.seen)
                    begin
                        res_empty_next = 1'b0;
                        res_value_next = rd_data_reg.value;
                        if (is_min || is_max)
                        begin
                            res_index_next = {1'b0, rd_data_reg.index};
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            mode_reg      <= MODE_SUM;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            grp_reg <= group_id;
            val_reg <= element_value;
            pos_reg <= position_in_group;
        end
        if (res_valid_next)
        begin
            res_group_reg <= grp_reg;
            res_value_reg <= res_value_next;
            res_index_reg <= res_index_next;
            res_empty_reg <= res_empty_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_group = res_group_reg;
    assign result_value = res_value_reg;
    assign result_index = res_index_reg;
    assign group_empty  = res_empty_reg;

    `SSMM_ASSERT_NEXT(a_one_cycle_strobe, result_valid, !result_valid,
        "result strobe lasted more than one cycle")
    `SSMM_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy,
        "block not busy after taking a word")
    `SSMM_ASSERT_SAME(a_result_from_readout, result_valid,
        $past(start && !busy && (req_type == REQ_READ), 2),
        "result without a readout word two cycles earlier")
    `SSMM_ASSERT_SAME(a_empty_result, result_valid && group_empty,
        (result_value == '0) && (result_index == '1),
        "empty group reported with a value or an index")

endmodule
